// ----- hw/rtl/epma_pkg.sv -----
`timescale 1ns / 1ps
package epma_pkg;

   // Plane geometry
   localparam int PLANE_ADDR_BITS_DEFAULT = 16;
   localparam int CPU_ADDR_W = 16;
   localparam int PLANE_COUNT = 4;
   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MEM_ENABLE       = 3'd0,
      CSR_ADDRESS_MODES    = 3'd1,
      CSR_READ_PLANE       = 3'd2,
      CSR_COMPARE_SETUP    = 3'd3,
      CSR_PLANE_WRITE_MASK = 3'd4,
      CSR_WRITE_SETUP      = 3'd5,
      CSR_SET_RESET_SETUP  = 3'd6,
      CSR_BIT_MASK         = 3'd7
   } csr_index_type;

   // Write modes (mode 3 behaves as mode 0)
   typedef enum logic [1:0] {
      WMODE_ROTATE  = 2'd0,
      WMODE_LATCH   = 2'd1,
      WMODE_EXPAND  = 2'd2,
      WMODE_ALIAS0  = 2'd3
   } write_mode_type;

   // ALU functions
   typedef enum logic [1:0] {
      ALU_NONE = 2'd0,
      ALU_AND  = 2'd1,
      ALU_OR   = 2'd2,
      ALU_XOR  = 2'd3
   } alu_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_READ_WAIT
   } state_type;

   // Settings the write data path needs
   typedef struct packed {
      logic       odd_even;
      logic [3:0] plane_write_mask;
      logic [6:0] write_setup;
      logic [7:0] set_reset_setup;
      logic [7:0] bit_mask;
   } wcfg_type;

endpackage

// ----- hw/rtl/epma_plane_ram.sv -----
`timescale 1ns / 1ps
module epma_plane_ram #(
   parameter int ADDR_BITS = epma_pkg::PLANE_ADDR_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic [ADDR_BITS-1:0]          addr,
   input  logic                          read_enable,
   input  logic [epma_pkg::PLANE_COUNT-1:0] byte_enable,
   input  logic [epma_pkg::WORD_W-1:0]   write_word,
   output logic [epma_pkg::WORD_W-1:0]   read_word
);
   import epma_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] read_word_ff;

   // Per-plane byte writes
   always_ff @(posedge clock) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         if (byte_enable[i]) begin
            mem_ff[addr][8*i +: 8] <= write_word[8*i +: 8];
         end
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_word_ff <= mem_ff[addr];
      end
   end

   assign read_word = read_word_ff;

endmodule

// ----- hw/rtl/epma_write_path.sv -----
`timescale 1ns / 1ps
module epma_write_path (
   input  logic                             enable,
   input  logic                             addr_odd,
   input  epma_pkg::wcfg_type               cfg,
   input  logic [epma_pkg::WORD_W-1:0]      latches,
   input  logic [7:0]                       cpu_data,
   output logic [epma_pkg::WORD_W-1:0]      write_word,
   output logic [epma_pkg::PLANE_COUNT-1:0] byte_enable
);
   import epma_pkg::*;

   write_mode_type mode;
   alu_type        alu;
   logic [2:0]     rot;
   logic [15:0]    rot_wide;
   logic [7:0]     rotated;
   logic [3:0]     pmask;

   assign mode     = write_mode_type'(cfg.write_setup[1:0]);
   assign alu      = alu_type'(cfg.write_setup[3:2]);
   assign rot      = cfg.write_setup[6:4];
   assign rot_wide = {cpu_data, cpu_data} >> rot;
   assign rotated  = rot_wide[7:0];

   // Odd/even steers even addresses to planes 0/2, odd to 1/3
   always_comb begin
      pmask = cfg.plane_write_mask;
      if (cfg.odd_even) begin
         pmask = addr_odd ? (pmask & 4'b1010) : (pmask & 4'b0101);
      end
      byte_enable = enable ? pmask : '0;
   end

   // Per-plane data formation, ALU and bit mask
   always_comb begin
      logic [7:0] latch;
      logic [7:0] val;
      write_word = '0;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         latch = latches[8*i +: 8];
         case (mode)
            WMODE_EXPAND: val = cpu_data[i] ? BYTE_ALL_ONES : 8'h00;
            default: begin
               if (cfg.set_reset_setup[4+i]) begin
                  val = cfg.set_reset_setup[i] ? BYTE_ALL_ONES : 8'h00;
               end else begin
                  val = rotated;
               end
            end
         endcase
         case (alu)
            ALU_AND: val = val & latch;
            ALU_OR:  val = val | latch;
            ALU_XOR: val = val ^ latch;
            default: val = val;
         endcase
         val = latch ^ ((val ^ latch) & cfg.bit_mask);
         if (mode == WMODE_LATCH) begin
            val = latch;
         end
         write_word[8*i +: 8] = val;
      end
   end

endmodule

// ----- hw/rtl/ega_planar_memory_access.sv -----
`timescale 1ns / 1ps
// Write: planes updated at the accepting edge, no response.
// Read: plane RAM read at the transfer edge; latch load, compare and response
// register follow in the cycle after. Next request taken after the response is
// registered, at the earliest together with the response transfer.
// Throughput: one write per cycle unless a response stalls; no request is taken
// during a read. Reset (synchronous, active high) clears latches, state, response
// valid and configuration registers; plane contents are undefined until written.
module ega_planar_memory_access #(
   parameter int PLANE_ADDR_BITS = epma_pkg::PLANE_ADDR_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [epma_pkg::CPU_ADDR_W-1:0]    req_cpu_address,
   input  logic [7:0]                         req_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_read_data,
   input  logic                               csr_write_enable,
   input  logic [epma_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [epma_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import epma_pkg::*;

   localparam int CHAIN_BIT = (PLANE_ADDR_BITS == 14) ? 13 : 15;

   // Configuration registers
   logic       mem_enable_ff;
   logic [1:0] address_modes_ff;
   logic [1:0] read_plane_ff;
   logic [8:0] compare_setup_ff;
   logic [3:0] plane_write_mask_ff;
   logic [6:0] write_setup_ff;
   logic [7:0] set_reset_setup_ff;
   logic [7:0] bit_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_enable_ff       <= 1'b1;
         address_modes_ff    <= '0;
         read_plane_ff       <= '0;
         compare_setup_ff    <= '0;
         plane_write_mask_ff <= 4'hF;
         write_setup_ff      <= '0;
         set_reset_setup_ff  <= '0;
         bit_mask_ff         <= BYTE_ALL_ONES;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MEM_ENABLE:       mem_enable_ff       <= csr_write_data[0];
            CSR_ADDRESS_MODES:    address_modes_ff    <= csr_write_data[1:0];
            CSR_READ_PLANE:       read_plane_ff       <= csr_write_data[1:0];
            CSR_COMPARE_SETUP:    compare_setup_ff    <= csr_write_data;
            CSR_PLANE_WRITE_MASK: plane_write_mask_ff <= csr_write_data[3:0];
            CSR_WRITE_SETUP:      write_setup_ff      <= csr_write_data[6:0];
            CSR_SET_RESET_SETUP:  set_reset_setup_ff  <= csr_write_data[7:0];
            CSR_BIT_MASK:         bit_mask_ff         <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Control state
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0] latches_ff, latches_in;
   logic              rd_enabled_ff, rd_enabled_in;
   logic [1:0]        rd_plane_ff, rd_plane_in;

   logic req_xfer;
   logic rd_xfer;
   logic wr_xfer;

   // Address remap: odd/even clears bit 0 on writes, chain replaces it
   logic [CPU_ADDR_W-1:0]      addr_oe;
   logic [CPU_ADDR_W-1:0]      addr_chain;
   logic [PLANE_ADDR_BITS-1:0] ram_addr;

   always_comb begin
      addr_oe = req_cpu_address;
      if (address_modes_ff[0] && req_opcode) begin
         addr_oe[0] = 1'b0;
      end
      addr_chain = addr_oe;
      if (address_modes_ff[1]) begin
         addr_chain[0] = addr_oe[CHAIN_BIT];
      end
   end
   assign ram_addr = addr_chain[PLANE_ADDR_BITS-1:0];

   // Write data path
   wcfg_type          wcfg;
   logic [WORD_W-1:0] write_word;
   logic [PLANE_COUNT-1:0] byte_enable;
   logic [WORD_W-1:0] read_word;

   assign wcfg = '{odd_even:         address_modes_ff[0],
                   plane_write_mask: plane_write_mask_ff,
                   write_setup:      write_setup_ff,
                   set_reset_setup:  set_reset_setup_ff,
                   bit_mask:         bit_mask_ff};

   epma_write_path u_write_path (
      .enable      (wr_xfer && mem_enable_ff),
      .addr_odd    (req_cpu_address[0]),
      .cfg         (wcfg),
      .latches     (latches_ff),
      .cpu_data    (req_write_data),
      .write_word  (write_word),
      .byte_enable (byte_enable)
   );

   epma_plane_ram #(
      .ADDR_BITS (PLANE_ADDR_BITS)
   ) u_plane_ram (
      .clock       (clock),
      .addr        (ram_addr),
      .read_enable (rd_xfer && mem_enable_ff),
      .byte_enable (byte_enable),
      .write_word  (write_word),
      .read_word   (read_word)
   );

   // Handshake
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rd_xfer   = req_xfer && !req_opcode;
   assign wr_xfer   = req_xfer && req_opcode;

   // Color compare over the word just read
   logic [7:0] compare_byte;
   always_comb begin
      compare_byte = BYTE_ALL_ONES;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         if (compare_setup_ff[4+i]) begin
            compare_byte = compare_byte
               & ~(read_word[8*i +: 8] ^ {8{compare_setup_ff[i]}});
         end
      end
   end

   // Next state and outputs
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      latches_in    = latches_ff;
      rd_enabled_in = rd_enabled_ff;
      rd_plane_in   = rd_plane_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (rd_xfer) begin
               rd_enabled_in = mem_enable_ff;
               rd_plane_in   = address_modes_ff[0]
                             ? {read_plane_ff[1], req_cpu_address[0]} : read_plane_ff;
               state_in      = ST_READ_WAIT;
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            if (!rd_enabled_ff) begin
               rsp_data_in = BYTE_ALL_ONES;
            end else begin
               latches_in  = read_word;
               rsp_data_in = compare_setup_ff[8] ? compare_byte
                                                 : read_word[8*rd_plane_ff +: 8];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         latches_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         latches_ff   <= latches_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rd_enabled_ff <= rd_enabled_in;
      rd_plane_ff   <= rd_plane_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ----- hw/rtl/epma_checker.sv -----
`timescale 1ns / 1ps
module epma_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response dropped or changed while stalled");

   // A read transfer is followed by a response
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_opcode |-> ##2 rsp_valid)
      else $error("read response missing");

   // No new request while a read is in flight
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_opcode |=> !req_ready)
      else $error("request taken during read");

   // A write never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode && !rsp_valid |=> !rsp_valid)
      else $error("response after write");

endmodule

bind ega_planar_memory_access epma_checker u_epma_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_opcode    (req_opcode),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data)
);

// ----- sim/ega_planar_memory_access_tb.sv -----
`timescale 1ns / 1ps
module ega_planar_memory_access_tb;
   import epma_pkg::*;

   localparam int  PLANE_BITS       = PLANE_ADDR_BITS_DEFAULT;
   localparam int  CHAIN_BIT        = (PLANE_BITS == 14) ? 13 : 15;
   localparam int  PLANE_SPAN_MASK  = (1 << PLANE_BITS) - 1;
   localparam int  SETTLE_CYCLES    = 4;
   localparam int  CYCLE_LIMIT      = 200000;
   localparam int  PHASE_COUNT      = 12;
   localparam int  ITEMS_PER_PHASE  = 150;
   localparam logic OP_READ         = 1'b0;
   localparam logic OP_WRITE        = 1'b1;

   // DUT interface
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_opcode = OP_READ;
   logic [CPU_ADDR_W-1:0]    req_cpu_address = '0;
   logic [7:0]               req_write_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [7:0]               rsp_read_data;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   // Shadow of the block's registers and state
   logic        shadow_mem_enable;
   logic [1:0]  shadow_address_modes;
   logic [1:0]  shadow_read_plane;
   logic [8:0]  shadow_compare_setup;
   logic [3:0]  shadow_plane_write_mask;
   logic [6:0]  shadow_write_setup;
   logic [7:0]  shadow_set_reset_setup;
   logic [7:0]  shadow_bit_mask;
   logic [31:0] shadow_latches;
   logic [31:0] plane_image [logic [15:0]];

   // Checking
   logic [7:0]  expected_read_data [$];
   logic [7:0]  head_read_data;
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   // Addresses that reads may touch; pairs differing in bit 0 only
   logic [15:0] mapped_addrs [$];

   // Directed stimulus table
   typedef struct {
      bit            is_csr;
      csr_index_type idx;
      logic [8:0]    value;
      logic          op;
      logic [15:0]   addr;
      logic [7:0]    data;
      bit            typed;
      logic [7:0]    want;
   } directed_row_type;

   directed_row_type directed_rows [$];

   ega_planar_memory_access #(
      .PLANE_ADDR_BITS(PLANE_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_cpu_address  (req_cpu_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response check and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_read_data.size() == 0) begin
            $error("read_data: no transfer pending, actual %02h", rsp_read_data);
            error_count++;
         end else begin
            head_read_data = expected_read_data.pop_front();
            if (rsp_read_data !== head_read_data) begin
               $error("read_data mismatch: expected %02h, actual %02h",
                      head_read_data, rsp_read_data);
               error_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Register shadow update, same field masks as the block
   function automatic void apply_register(input csr_index_type idx, input logic [8:0] value);
      case (idx)
         CSR_MEM_ENABLE:       shadow_mem_enable       = value[0];
         CSR_ADDRESS_MODES:    shadow_address_modes    = value[1:0];
         CSR_READ_PLANE:       shadow_read_plane       = value[1:0];
         CSR_COMPARE_SETUP:    shadow_compare_setup    = value[8:0];
         CSR_PLANE_WRITE_MASK: shadow_plane_write_mask = value[3:0];
         CSR_WRITE_SETUP:      shadow_write_setup      = value[6:0];
         CSR_SET_RESET_SETUP:  shadow_set_reset_setup  = value[7:0];
         CSR_BIT_MASK:         shadow_bit_mask         = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [8:0] register_max(input csr_index_type idx);
      case (idx)
         CSR_MEM_ENABLE:       return 9'd1;
         CSR_ADDRESS_MODES:    return 9'd3;
         CSR_READ_PLANE:       return 9'd3;
         CSR_COMPARE_SETUP:    return 9'd511;
         CSR_PLANE_WRITE_MASK: return 9'd15;
         CSR_WRITE_SETUP:      return 9'd127;
         default:              return 9'd255;
      endcase
   endfunction

   // Chain odd/even remap and wrap into the plane span
   function automatic logic [15:0] chain_map(input logic [15:0] a);
      logic [15:0] m;
      m = a;
      if (shadow_address_modes[1])
         m[0] = a[CHAIN_BIT];
      return m & 16'(PLANE_SPAN_MASK);
   endfunction

   // Planar access: updates shadow state, gives the read byte for reads
   task automatic model_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] data, output bit has_rsp,
                               output logic [7:0] rsp);
      logic [1:0]     plane;
      logic [15:0]    ea;
      logic [15:0]    a;
      logic [31:0]    word;
      logic [3:0]     pmask;
      logic [7:0]     lat;
      logic [7:0]     val;
      logic [15:0]    doubled;
      write_mode_type mode;
      alu_type        alu;
      logic [2:0]     rot;
      has_rsp = 1'b0;
      rsp     = '0;
      a       = addr;
      if (op == OP_READ) begin
         has_rsp = 1'b1;
         if (!shadow_mem_enable) begin
            rsp = BYTE_ALL_ONES;
         end else begin
            plane = shadow_read_plane;
            if (shadow_address_modes[0])
               plane[0] = a[0];
            ea = chain_map(a);
            shadow_latches = plane_image.exists(ea) ? plane_image[ea] : 32'h0;
            if (shadow_compare_setup[8]) begin
               rsp = BYTE_ALL_ONES;
               for (int i = 0; i < PLANE_COUNT; i++) begin
                  if (shadow_compare_setup[4+i])
                     rsp &= ~(shadow_latches[8*i +: 8] ^ {8{shadow_compare_setup[i]}});
               end
            end else begin
               rsp = shadow_latches[8*plane +: 8];
            end
         end
      end else if (shadow_mem_enable) begin
         pmask = shadow_plane_write_mask;
         mode  = write_mode_type'(shadow_write_setup[1:0]);
         alu   = alu_type'(shadow_write_setup[3:2]);
         rot   = shadow_write_setup[6:4];
         // odd/even steers even bytes to planes 0/2, odd to 1/3
         if (shadow_address_modes[0]) begin
            if (a[0])
               pmask &= 4'b1010;
            else
               pmask &= 4'b0101;
            a[0] = 1'b0;
         end
         ea   = chain_map(a);
         word = plane_image.exists(ea) ? plane_image[ea] : 32'h0;
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (pmask[i]) begin
               lat = shadow_latches[8*i +: 8];
               if (mode == WMODE_LATCH) begin
                  val = lat;
               end else begin
                  if (mode == WMODE_EXPAND) begin
                     val = {8{data[i]}};
                  end else if (shadow_set_reset_setup[4+i]) begin
                     val = {8{shadow_set_reset_setup[i]}};
                  end else begin
                     doubled = {data, data} >> rot;
                     val     = doubled[7:0];
                  end
                  case (alu)
                     ALU_AND: val &= lat;
                     ALU_OR:  val |= lat;
                     ALU_XOR: val ^= lat;
                     default: ;
                  endcase
                  val = lat ^ ((val ^ lat) & shadow_bit_mask);
               end
               word[8*i +: 8] = val;
            end
         end
         plane_image[ea] = word;
      end
   endtask

   // One request transfer, with random sender gaps
   task automatic send_request(input logic op, input logic [15:0] addr,
                               input logic [7:0] data, input bit typed,
                               input logic [7:0] want);
      bit         has_rsp;
      logic [7:0] rsp;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_cpu_address <= addr;
      req_write_data  <= data;
      do @(posedge clock); while (!req_ready);
      model_access(op, addr, data, has_rsp, rsp);
      if (has_rsp)
         expected_read_data.push_back(typed ? want : rsp);
   endtask

   // Wait for the block to go idle
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_read_data.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [8:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      apply_register(idx, value);
   endtask

   function automatic void add_csr(input csr_index_type idx, input logic [8:0] value);
      directed_row_type r;
      r = '{is_csr: 1'b1, idx: idx, value: value, op: OP_READ, addr: '0, data: '0,
            typed: 1'b0, want: '0};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_req(input logic op, input logic [15:0] addr,
                                   input logic [7:0] data, input bit typed,
                                   input logic [7:0] want);
      directed_row_type r;
      r = '{is_csr: 1'b0, idx: CSR_MEM_ENABLE, value: '0, op: op, addr: addr,
            data: data, typed: typed, want: want};
      directed_rows.push_back(r);
   endfunction

   function automatic void build_directed;
      // full-byte writes and reads at the address extremes
      add_req(OP_WRITE, 16'h0000, 8'hA5, 1'b0, 8'h00);
      add_req(OP_READ,  16'h0000, 8'h00, 1'b1, 8'hA5);
      add_req(OP_WRITE, 16'hFFFF, 8'h00, 1'b0, 8'h00);
      add_req(OP_READ,  16'hFFFF, 8'hFF, 1'b1, 8'h00);
      add_req(OP_WRITE, 16'hFFFE, 8'hFF, 1'b0, 8'h00);
      add_req(OP_READ,  16'hFFFE, 8'h00, 1'b1, 8'hFF);
      add_csr(CSR_READ_PLANE, 9'd3);
      add_req(OP_READ,  16'hFFFE, 8'h00, 1'b1, 8'hFF);
      // data-bit expansion: planes 0/2 all ones, 1/3 all zeros
      add_csr(CSR_WRITE_SETUP, 9'd2);
      add_req(OP_WRITE, 16'h0001, 8'h05, 1'b0, 8'h00);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b1, 8'h00);
      add_csr(CSR_READ_PLANE, 9'd2);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b1, 8'hFF);
      // compare read: no plane selected, then match and full mismatch
      add_csr(CSR_COMPARE_SETUP, 9'h100);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b1, 8'hFF);
      add_csr(CSR_COMPARE_SETUP, 9'h1F5);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b1, 8'hFF);
      add_csr(CSR_COMPARE_SETUP, 9'h1FA);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b1, 8'h00);
      // latch copy
      add_csr(CSR_COMPARE_SETUP, 9'h000);
      add_csr(CSR_WRITE_SETUP, 9'd1);
      add_req(OP_WRITE, 16'h1234, 8'h3C, 1'b0, 8'h00);
      add_req(OP_READ,  16'h1234, 8'h00, 1'b1, 8'hFF);
      // mode 3 with xor, rotate 7, partial set/reset
      add_csr(CSR_WRITE_SETUP, 9'h7F);
      add_csr(CSR_SET_RESET_SETUP, 9'h3C);
      add_req(OP_WRITE, 16'h1235, 8'h81, 1'b0, 8'h00);
      add_req(OP_READ,  16'h1235, 8'h00, 1'b0, 8'h00);
      // chain plus odd/even, bit mask closed, two planes enabled
      add_csr(CSR_BIT_MASK, 9'h00);
      add_csr(CSR_PLANE_WRITE_MASK, 9'hA);
      add_csr(CSR_ADDRESS_MODES, 9'd3);
      add_req(OP_WRITE, 16'h8000, 8'h5A, 1'b0, 8'h00);
      add_req(OP_READ,  16'h8001, 8'h00, 1'b0, 8'h00);
      add_req(OP_READ,  16'h8000, 8'h00, 1'b0, 8'h00);
      // memory disabled
      add_csr(CSR_MEM_ENABLE, 9'd0);
      add_req(OP_READ,  16'h4321, 8'h00, 1'b1, 8'hFF);
      add_req(OP_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00);
      // odd/even alone: both bytes land in word 0, read keeps the address
      add_csr(CSR_MEM_ENABLE, 9'd1);
      add_csr(CSR_ADDRESS_MODES, 9'd1);
      add_csr(CSR_BIT_MASK, 9'hFF);
      add_csr(CSR_PLANE_WRITE_MASK, 9'hF);
      add_csr(CSR_WRITE_SETUP, 9'd0);
      add_req(OP_WRITE, 16'h0000, 8'h11, 1'b0, 8'h00);
      add_req(OP_WRITE, 16'h0001, 8'h22, 1'b0, 8'h00);
      add_req(OP_READ,  16'h0000, 8'h00, 1'b1, 8'h11);
      add_req(OP_READ,  16'h0001, 8'h00, 1'b0, 8'h00);
   endfunction

   // Stimulus
   initial begin
      logic [15:0] base;
      logic [15:0] addr;
      logic [8:0]  cfg [8];
      logic        op;
      bit          csr_open;

      shadow_mem_enable       = 1'b1;
      shadow_address_modes    = '0;
      shadow_read_plane       = '0;
      shadow_compare_setup    = '0;
      shadow_plane_write_mask = 4'hF;
      shadow_write_setup      = '0;
      shadow_set_reset_setup  = '0;
      shadow_bit_mask         = 8'hFF;
      shadow_latches          = '0;

      // address pairs; the remaps only touch bit 0, so reads stay inside the set
      mapped_addrs = {16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF,
                      16'h1234, 16'h1235, 16'h8000, 16'h8001};
      repeat (12) begin
         base = 16'($urandom) & 16'hFFFE;
         mapped_addrs.push_back(base);
         mapped_addrs.push_back(base | 16'h0001);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // preload every readable location, all planes, reset settings
      foreach (mapped_addrs[i])
         send_request(OP_WRITE, mapped_addrs[i], 8'($urandom), 1'b0, 8'h00);

      // directed table
      build_directed();
      csr_open = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            if (!csr_open)
               drain();
            write_register(directed_rows[i].idx, directed_rows[i].value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_write_enable <= 1'b0;
               csr_open = 1'b0;
            end
            send_request(directed_rows[i].op, directed_rows[i].addr,
                         directed_rows[i].data, directed_rows[i].typed,
                         directed_rows[i].want);
         end
      end
      if (csr_open)
         csr_write_enable <= 1'b0;

      // random phases, each with its own settings and idling
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         for (int r = 0; r < 8; r++) begin
            case (ph)
               0:       cfg[r] = (r == CSR_MEM_ENABLE) ? 9'd1 : 9'd0;
               1:       cfg[r] = register_max(csr_index_type'(r));
               default: cfg[r] = 9'($urandom_range(register_max(csr_index_type'(r))));
            endcase
         end
         cfg[CSR_MEM_ENABLE] = (ph == 2) ? 9'd0 : 9'd1;
         for (int r = 0; r < 8; r++)
            write_register(csr_index_type'(r), cfg[r]);
         csr_write_enable <= 1'b0;

         case (ph % 4)
            1: send_idle_pct = 55;
            2: recv_stall_pct = 55;
            3: begin
               send_idle_pct  = 33;
               recv_stall_pct = 33;
            end
            default: ;
         endcase

         repeat (ITEMS_PER_PHASE) begin
            op   = $urandom_range(1) ? OP_WRITE : OP_READ;
            addr = mapped_addrs[$urandom_range(mapped_addrs.size() - 1)];
            // any address is safe for writes and for disabled reads
            if ((op == OP_WRITE || !shadow_mem_enable) && $urandom_range(99) < 20)
               addr = 16'($urandom);
            send_request(op, addr, 8'($urandom), 1'b0, 8'h00);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
